// ----- sv/ttyld_pkg.sv -----
// ----------------------------------------------------------------------------
// ttyld_pkg
// Shared types and constants of the terminal input line discipline: item
// structs, command and character class codes, mode bits and control char slots.
// ----------------------------------------------------------------------------
package ttyld_pkg;

    // request commands
    typedef enum logic [1:0] {
        CMD_RX    = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // class of a received character after mapping
    typedef enum logic [2:0] {
        K_APPEND  = 3'd0,
        K_DROP    = 3'd1,
        K_INTR    = 3'd2,
        K_QUIT    = 3'd3,
        K_STOP    = 3'd4,
        K_START   = 3'd5,
        K_DISCARD = 3'd6,
        K_EDIT    = 3'd7
    } t_kind;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_PROC = 3'd1,
        S_TAKE = 3'd2,
        S_SCAN = 3'd3,
        S_DONE = 3'd4
    } t_state;

    // configuration register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_CTRL_CH = 2'd1;
    localparam logic [1:0] REG_DISCARD = 2'd2;

    // mode flag bit positions
    localparam int M_STRIP  = 0;
    localparam int M_IGNCR  = 1;
    localparam int M_CRNL   = 2;
    localparam int M_NLCR   = 3;
    localparam int M_FLOW   = 4;
    localparam int M_CANON  = 5;
    localparam int M_SIG    = 6;
    localparam int M_ECHO   = 7;
    localparam int M_ECHOE  = 8;
    localparam int M_ECHOK  = 9;
    localparam int M_POST   = 10;
    localparam int M_NLCRNL = 11;

    // control character byte slots
    localparam int CC_INTR  = 0;
    localparam int CC_QUIT  = 1;
    localparam int CC_ERASE = 2;
    localparam int CC_KILL  = 3;
    localparam int CC_EOF   = 4;
    localparam int CC_EOL   = 5;
    localparam int CC_STOP  = 6;
    localparam int CC_START = 7;

    // character and reset constants
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_NL        = 8'h0a;
    localparam logic [7:0]  CH_CR        = 8'h0d;
    localparam logic [7:0]  CH_ASCII     = 8'h7f;
    localparam logic [7:0]  DISCARD_RST  = 8'h0f;
    localparam logic [8:0]  ECHO_CNT_MAX = 9'd511;
    localparam logic [1:0]  SIG_NONE     = 2'd0;
    localparam logic [1:0]  SIG_INTR     = 2'd1;
    localparam logic [1:0]  SIG_QUIT     = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       echo_cr_first;
        logic [7:0] echo_char;
        logic       echo_valid;
        logic       beep;
        logic [8:0] erase_echo_count;
        logic [1:0] signal_code;
        logic       wake_reader;
        logic       accepted;
        logic       output_stopped;
        logic       output_discard;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec_rx;
        logic flush;
        logic rd_head;
        logic take_pop;
        logic scan_first;
        logic scan_pop;
        logic scan_next;
        logic publish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd  cmd;
        t_kind kind;
        logic  fill_zero;
        logic  scan_hit;
        logic  scan_one;
        logic  is_erase;
        logic  out_free;
    } t_dp_stat;

endpackage

// ----- sv/tty_input_line_discipline.sv -----
// ----------------------------------------------------------------------------
// tty_input_line_discipline
// Terminal input line discipline for one line: maps and classifies received
// bytes, keeps the input queue, and reports echo, signals and reader wake-up.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_in_item  (command, rx_byte)
//  out      | output    | o_out_valid / i_out_ready| o_out_item (one per request)
//  cfg      | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  one request at a time: idle, classify, then done; a take on a non-empty queue
//  adds a head read, erase and kill a backward walk that reads queue entries
//  (the entries removed and the line boundary that stops the walk).
//  the result sits in an output register; a new request is taken while it waits,
//  and that request holds in its done state until the register is free.
//  reset is synchronous and leaves the queue empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tty_input_line_discipline
    import ttyld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    ttyld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // queue, flags and result datapath
    ttyld_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ----- sv/ttyld_ram.sv -----
// ----------------------------------------------------------------------------
// ttyld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttyld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ttyld_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttyld_ctrl
// Sequencer of the line discipline: accepts a request, steers the datapath
// through classify, queue read, erase/kill walk and result publish.
// ----------------------------------------------------------------------------
module ttyld_ctrl
    import ttyld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PROC;
                end
            end
            S_PROC: begin
                unique case (i_stat.cmd)
                    CMD_RX: begin
                        if (i_stat.kind == K_EDIT) begin
                            if (i_stat.fill_zero) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.scan_first = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end else begin
                            o_cmd.exec_rx = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    CMD_TAKE: begin
                        if (i_stat.fill_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_head = 1'b1;
                            n_state       = S_TAKE;
                        end
                    end
                    CMD_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        n_state     = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_TAKE: begin
                o_cmd.take_pop = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                // stop at a line boundary, else drop the newest entry
                if (i_stat.scan_hit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_pop = 1'b1;
                    if (i_stat.is_erase || i_stat.scan_one) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ttyld_dpath.sv -----
// ----------------------------------------------------------------------------
// ttyld_dpath
// Datapath of the line discipline: configuration registers, character
// mapping and classification, queue pointers and flags, queue memory and
// the result register toward the output channel.
// ----------------------------------------------------------------------------
module ttyld_dpath
    import ttyld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = AW + 1;
    localparam int SW = AW + 2;
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(QUEUE_DEPTH - 1);

    // configuration
    logic [11:0] r_mode;
    logic [63:0] r_cc;
    logic [7:0]  r_disc;

    // queue and flags
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_stop, n_stop;
    logic          r_discard, n_discard;
    logic          r_out_valid, n_out_valid;

    // request and result payload
    t_in_item      r_in;
    t_out_item     r_res, n_res;
    t_out_item     w_pub;
    t_out_item     r_out;
    logic [AW-1:0] r_scan_ptr, n_scan_ptr;

    // queue memory ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    // mapping and classification
    logic [7:0]    w_c0, w_c1, w_c;
    logic          w_canon;
    t_kind         w_kind;
    logic [7:0]    w_cc_erase, w_cc_eol, w_cc_eof;

    // index arithmetic
    logic [SW-1:0] w_sum, w_sum_m1, w_tail_s, w_new_s;
    logic [AW-1:0] w_tail, w_newest, w_head_inc, w_scan_prev;
    logic          w_full, w_show;

    assign w_canon    = r_mode[M_CANON];
    assign w_cc_erase = r_cc[8*CC_ERASE +: 8];
    assign w_cc_eol   = r_cc[8*CC_EOL +: 8];
    assign w_cc_eof   = r_cc[8*CC_EOF +: 8];

    // parity strip and cr/nl mapping, then class by priority
    always_comb begin
        w_kind = K_APPEND;
        w_c0   = r_mode[M_STRIP] ? (r_in.rx_byte & CH_ASCII) : r_in.rx_byte;
        w_c1   = w_c0;
        if (w_c0 == CH_CR && r_mode[M_CRNL]) begin
            w_c1 = CH_NL;
        end
        w_c = (w_c1 == CH_NL && r_mode[M_NLCR]) ? CH_CR : w_c1;
        if (w_canon && w_c0 == CH_NUL) begin
            w_kind = K_DROP;
        end else if (w_c0 == CH_CR && r_mode[M_IGNCR]) begin
            w_kind = K_DROP;
        end else if (r_mode[M_SIG] && w_c == r_cc[8*CC_INTR +: 8]) begin
            w_kind = K_INTR;
        end else if (r_mode[M_SIG] && w_c == r_cc[8*CC_QUIT +: 8]) begin
            w_kind = K_QUIT;
        end else if (r_mode[M_FLOW] && w_c == r_cc[8*CC_STOP +: 8]) begin
            w_kind = K_STOP;
        end else if (r_mode[M_FLOW] && w_c == r_cc[8*CC_START +: 8]) begin
            w_kind = K_START;
        end else if (w_canon && w_c == r_disc) begin
            w_kind = K_DISCARD;
        end else if (w_canon && (w_c == w_cc_erase || w_c == r_cc[8*CC_KILL +: 8])) begin
            w_kind = K_EDIT;
        end
    end

    // circular queue indexes
    always_comb begin
        w_sum       = SW'(r_head) + SW'(r_fill);
        w_sum_m1    = w_sum - 1'b1;
        w_tail_s    = (w_sum >= DEPTH_S) ? w_sum - DEPTH_S : w_sum;
        w_new_s     = (w_sum_m1 >= DEPTH_S) ? w_sum_m1 - DEPTH_S : w_sum_m1;
        w_tail      = w_tail_s[AW-1:0];
        w_newest    = w_new_s[AW-1:0];
        w_head_inc  = (r_head == LAST_IX) ? '0 : r_head + 1'b1;
        w_scan_prev = (r_scan_ptr == '0) ? LAST_IX : r_scan_ptr - 1'b1;
        w_full      = (r_fill == DEPTH_F);
    end

    assign w_show = (w_c == w_cc_erase) ? r_mode[M_ECHOE] : r_mode[M_ECHOK];

    // memory port steering
    assign w_we    = i_cmd.exec_rx && (w_kind == K_APPEND) && !w_full;
    assign w_waddr = w_tail;
    assign w_re    = i_cmd.rd_head || i_cmd.scan_first || i_cmd.scan_next;
    always_comb begin
        w_raddr = r_head;
        if (i_cmd.scan_first) begin
            w_raddr = w_newest;
        end else if (i_cmd.scan_next) begin
            w_raddr = w_scan_prev;
        end
    end

    ttyld_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_c),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state of queue, flags and result
    always_comb begin
        n_head      = r_head;
        n_fill      = r_fill;
        n_stop      = r_stop;
        n_discard   = r_discard;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        n_scan_ptr  = r_scan_ptr;

        if (i_cmd.load_in) begin
            n_res          = '0;
            n_res.accepted = 1'b1;
        end

        // receive actions other than erase and kill
        if (i_cmd.exec_rx) begin
            case (w_kind)
                K_INTR, K_QUIT: begin
                    n_res.signal_code = (w_kind == K_INTR) ? SIG_INTR : SIG_QUIT;
                    n_head    = '0;
                    n_fill    = '0;
                    n_stop    = 1'b0;
                    n_discard = 1'b0;
                end
                K_STOP:    n_stop    = 1'b1;
                K_START:   n_stop    = 1'b0;
                K_DISCARD: n_discard = !r_discard;
                K_APPEND: begin
                    n_res.echo_cr_first = (w_c == CH_NL) && r_mode[M_POST]
                                          && r_mode[M_NLCRNL] && r_mode[M_ECHO];
                    if (!w_full) begin
                        n_fill = r_fill + 1'b1;
                        if (!(w_canon && w_c == w_cc_eof) && r_mode[M_ECHO]) begin
                            n_res.echo_char  = w_c;
                            n_res.echo_valid = 1'b1;
                        end
                    end else begin
                        n_res.beep = 1'b1;
                    end
                    n_res.wake_reader = !w_canon || w_c == w_cc_eol || w_c == CH_NL
                                        || w_c == w_cc_eof;
                    n_res.accepted    = !w_full;
                end
                default: ;
            endcase
        end

        if (i_cmd.flush) begin
            n_head = '0;
            n_fill = '0;
        end

        // take from the head
        if (i_cmd.take_pop) begin
            n_res.read_data  = w_rdata;
            n_res.read_valid = 1'b1;
            n_head           = w_head_inc;
            n_fill           = r_fill - 1'b1;
        end

        // erase and kill walk
        if (i_cmd.scan_first) begin
            n_scan_ptr = w_newest;
        end
        if (i_cmd.scan_next) begin
            n_scan_ptr = w_scan_prev;
        end
        if (i_cmd.scan_pop) begin
            n_fill = r_fill - 1'b1;
            if (w_show && r_res.erase_echo_count != ECHO_CNT_MAX) begin
                n_res.erase_echo_count = r_res.erase_echo_count + 1'b1;
            end
        end

        // output register handshake
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.publish) begin
            n_out_valid = 1'b1;
        end
    end

    // result with the flags after the request
    always_comb begin
        w_pub                = r_res;
        w_pub.output_stopped = r_stop;
        w_pub.output_discard = r_discard;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_cc        <= '0;
            r_disc      <= DISCARD_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_stop      <= 1'b0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:    r_mode <= i_cfg_data[11:0];
                    REG_CTRL_CH: r_cc   <= i_cfg_data;
                    REG_DISCARD: r_disc <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_stop      <= n_stop;
            r_discard   <= n_discard;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        r_res      <= n_res;
        r_scan_ptr <= n_scan_ptr;
        if (i_cmd.publish) begin
            r_out <= w_pub;
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.cmd       = t_cmd'(r_in.command);
        o_stat.kind      = w_kind;
        o_stat.fill_zero = (r_fill == '0);
        o_stat.scan_hit  = (w_rdata == CH_NL) || (w_rdata == w_cc_eol);
        o_stat.scan_one  = (r_fill == FW'(1));
        o_stat.is_erase  = (w_c == w_cc_erase);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
